@@ sv/bdpc_pkg.sv @@
`default_nettype none

package bdpc_pkg;

    // configuration register width and reset values
    localparam int unsigned CFG_W = 16;
    localparam logic [CFG_W-1:0] DEBOUNCE_TICKS_RST = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_TICKS_RST = 16'd1000;

    // default width of the tick counters
    localparam int unsigned COUNT_WIDTH_DEF = 16;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 1'b1;

    // per-tick result flags
    typedef struct packed {
        logic short_press;
        logic long_press;
        logic release_res;
        logic stable_level;
    } t_flags;

endpackage

`default_nettype wire

@@ sv/button_debounce_press_classifier_unit.sv @@
// Button debounce and press classifier.
// Input channel (i_valid / o_ready, i_pin_level): one beat per timebase tick
// carrying the raw active-low button level.
// Output channel (o_valid / i_ready): one beat per input beat with the flags
// short press, long press, release and the debounced level after that tick.
// Latency: the result beat is valid on the cycle after the input beat is taken.
// Throughput: one beat per cycle while the receiver keeps i_ready high; the
// single output register is refilled in the same cycle it is drained, so
// o_ready stays high while the receiver takes each result.
// When the receiver stalls, the pending result holds and o_ready drops until it
// is taken; the tick state advances only on accepted input beats.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 debounce ticks, 1 long-press ticks) in that cycle; write only while idle.
// Reset (synchronous, active low): debounce ticks 50, long-press ticks 1000,
// level released, both tick counters cleared, output register empty.
`default_nettype none

module button_debounce_press_classifier_unit #(
    parameter int unsigned COUNT_WIDTH = bdpc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic                            i_pin_level,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic                                 o_short_press,
    output logic                                 o_long_press,
    output logic                                 o_release_res,
    output logic                                 o_stable_level,
    input  wire logic                            i_cfg_we,
    input  wire logic [bdpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [bdpc_pkg::CFG_W-1:0]      i_cfg_data
);

    logic [bdpc_pkg::CFG_W-1:0] r_debounce_ticks;
    logic [bdpc_pkg::CFG_W-1:0] r_long_press_ticks;
    logic                       r_valid;
    bdpc_pkg::t_flags           r_flags;
    bdpc_pkg::t_flags           n_flags;
    logic                       step;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks   <= bdpc_pkg::DEBOUNCE_TICKS_RST;
            r_long_press_ticks <= bdpc_pkg::LONG_PRESS_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bdpc_pkg::REG_DEBOUNCE_TICKS:   r_debounce_ticks   <= i_cfg_data;
                bdpc_pkg::REG_LONG_PRESS_TICKS: r_long_press_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input beat taken when the output register is free or draining
    assign o_ready = !r_valid || i_ready;
    assign step    = i_valid && o_ready;

    bdpc_tick #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_tick (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (step),
        .i_pin_level        (i_pin_level),
        .i_debounce_ticks   (r_debounce_ticks),
        .i_long_press_ticks (r_long_press_ticks),
        .o_flags            (n_flags)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_flags <= n_flags;
        end
    end

    assign o_valid        = r_valid;
    assign o_short_press  = r_flags.short_press;
    assign o_long_press   = r_flags.long_press;
    assign o_release_res  = r_flags.release_res;
    assign o_stable_level = r_flags.stable_level;

    // a short press only comes with a release
    a_short_needs_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_short_press) |-> o_release_res)
        else $error("short press without release");

    // a release leaves the level released
    a_release_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_release_res) |-> o_stable_level)
        else $error("release with pressed level");

    // a long press only fires while pressed
    a_long_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_long_press) |-> !o_stable_level)
        else $error("long press with released level");

    // a taken input beat always yields a result beat next cycle
    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> o_valid)
        else $error("result beat missing");

endmodule

`default_nettype wire

@@ sv/bdpc_tick.sv @@
`default_nettype none

module bdpc_tick #(
    parameter int unsigned COUNT_WIDTH = bdpc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic                        i_pin_level,
    input  wire logic [bdpc_pkg::CFG_W-1:0]  i_debounce_ticks,
    input  wire logic [bdpc_pkg::CFG_W-1:0]  i_long_press_ticks,
    output bdpc_pkg::t_flags                 o_flags
);

    localparam int unsigned CMP_W =
        (COUNT_WIDTH > bdpc_pkg::CFG_W) ? COUNT_WIDTH : bdpc_pkg::CFG_W;

    logic                   r_previous_raw, n_previous_raw;
    logic                   r_debounced, n_debounced;
    logic [COUNT_WIDTH-1:0] r_change_age, n_change_age;
    logic [COUNT_WIDTH-1:0] r_press_age, n_press_age;
    logic                   r_long_fired, n_long_fired;

    logic [COUNT_WIDTH-1:0] press_inc;
    logic                   accept_level;

    // one tick of the debounce and press classification
    always_comb begin
        n_previous_raw = i_pin_level;
        n_debounced    = r_debounced;
        n_long_fired   = r_long_fired;
        o_flags        = '0;

        // change age restarts on a raw edge, otherwise saturating count
        if (i_pin_level != r_previous_raw) begin
            n_change_age = '0;
        end else if (r_change_age == {COUNT_WIDTH{1'b1}}) begin
            n_change_age = r_change_age;
        end else begin
            n_change_age = r_change_age + COUNT_WIDTH'(1);
        end

        if (r_press_age == {COUNT_WIDTH{1'b1}}) begin
            press_inc = r_press_age;
        end else begin
            press_inc = r_press_age + COUNT_WIDTH'(1);
        end
        n_press_age = press_inc;

        accept_level = (CMP_W'(n_change_age) > CMP_W'(i_debounce_ticks))
                       && (i_pin_level != r_debounced);

        // accepted level change: press restarts the age, release classifies
        if (accept_level) begin
            n_debounced = i_pin_level;
            if (!i_pin_level) begin
                n_press_age  = '0;
                n_long_fired = 1'b0;
            end else begin
                o_flags.short_press = !r_long_fired
                    && (CMP_W'(press_inc) < CMP_W'(i_long_press_ticks));
                o_flags.release_res = 1'b1;
            end
        end

        // long press fires once per held press
        if (!n_debounced && !n_long_fired
            && (CMP_W'(n_press_age) >= CMP_W'(i_long_press_ticks))) begin
            o_flags.long_press = 1'b1;
            n_long_fired       = 1'b1;
        end

        o_flags.stable_level = n_debounced;
    end

    // state advances once per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_previous_raw <= 1'b1;
            r_debounced    <= 1'b1;
            r_change_age   <= '0;
            r_press_age    <= '0;
            r_long_fired   <= 1'b0;
        end else if (i_step) begin
            r_previous_raw <= n_previous_raw;
            r_debounced    <= n_debounced;
            r_change_age   <= n_change_age;
            r_press_age    <= n_press_age;
            r_long_fired   <= n_long_fired;
        end
    end

endmodule

`default_nettype wire
